// File: hw/rtl/nocase_multi_pattern_name_match_macros.svh
// Assertion macros for the name matcher.
`ifndef NOCASE_MULTI_PATTERN_NAME_MATCH_MACROS_SVH
`define NOCASE_MULTI_PATTERN_NAME_MATCH_MACROS_SVH

// Same-cycle implication, held off during reset.
`define NMPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define NMPM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/nmpm_pkg.sv
// Types, codes and helpers shared by the name matcher.
`timescale 1ns / 1ps
`default_nettype none

package nmpm_pkg;

  localparam int NUM_SLOTS_DEF       = 128;
  localparam int MAX_PATTERN_LEN_DEF = 32;

  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5a;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CASE_OFFSET = CH_LOWER_A - CH_UPPER_A;

  typedef enum logic [1:0] {
    CMD_PAT_BYTE  = 2'd0,
    CMD_SLOT_CFG  = 2'd1,
    CMD_NAME_BYTE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_PREFIX   = 2'd0,
    MODE_EXACT    = 2'd1,
    MODE_CONTAINS = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_SCAN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] slot;
    logic [4:0] position;
    logic [7:0] data_byte;
    logic [5:0] pattern_len_in;
    logic [1:0] match_mode;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic       matched;
    logic [6:0] match_slot;
  } out_word_t;

  // ASCII upper case to lower case, everything else untouched
  function automatic logic [7:0] fold_char(input logic [7:0] ch);
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      return ch + CASE_OFFSET;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/nmpm_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module nmpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/nocase_multi_pattern_name_match.sv
// Top level of the case-insensitive multi-pattern name matcher.
//
//  channel  direction  handshake                payload
//  in       input      in_valid_i / in_ready_o   in_data_i  (in_word_t)
//  out      output     out_valid_o / out_ready_i out_data_o (out_word_t)
//
// Pattern byte or slot length/mode write: read, modify, write back.
// Name byte: one slot per cycle through the slot memory read/update/write pipeline;
// a last byte then goes on to load the result.
// After reset a clearing pass zeroes the slot table; no word is taken meanwhile.
// A result waiting on out stalls only the next name end.
`timescale 1ns / 1ps
`default_nettype none
`include "nocase_multi_pattern_name_match_macros.svh"

module nocase_multi_pattern_name_match
  import nmpm_pkg::*;
#(
  parameter int NUM_SLOTS       = NUM_SLOTS_DEF,
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o
);

  localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW     = $clog2(NUM_SLOTS + 1);
  localparam int LW     = $clog2(MAX_PATTERN_LEN + 1);
  localparam int PW     = $clog2(MAX_PATTERN_LEN);
  localparam int PSW    = $clog2(MAX_PATTERN_LEN + 2);
  localparam int PAT_W  = MAX_PATTERN_LEN * 8;
  // slot word: {found, window, alive, mode, length}
  localparam int MODE_LO  = LW;
  localparam int ALIVE_B  = LW + 2;
  localparam int WIN_LO   = LW + 3;
  localparam int FOUND_B  = LW + 3 + MAX_PATTERN_LEN;
  localparam int SLOT_W   = LW + 4 + MAX_PATTERN_LEN;

  state_e state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [PSW-1:0] npos_q, npos_d;
  logic           best_hit_q, best_hit_d;
  logic [SW-1:0]  best_slot_q, best_slot_d;
  logic [SW-1:0]  ridx_q;
  in_word_t       item_q;
  logic           out_valid_q, out_valid_d;
  out_word_t      out_data_q;

  logic              accept;
  logic              out_load;
  logic              slot_ok, pos_ok;
  logic [SW-1:0]     raddr, waddr;
  logic              pat_we, slot_we;
  logic [PAT_W-1:0]  pat_rdata, pat_wdata;
  logic [SLOT_W-1:0] slot_rdata, slot_wdata, slot_upd;
  logic              scan_wr;

  // scan datapath
  logic [LW-1:0]              len;
  logic [1:0]                 mode;
  logic                       first_byte;
  logic                       alive_o, alive_n, found_o, found_n, kill;
  logic [MAX_PATTERN_LEN-1:0] win_o, win_n, eq;
  logic [7:0]                 ch;
  logic [PSW-1:0]             pos_n;
  logic                       slot_hit;
  logic [LW-1:0]              len_sat;

  assign accept  = in_valid_i && in_ready_o;
  assign slot_ok = int'(item_q.slot) < NUM_SLOTS;
  assign pos_ok  = int'(item_q.position) < MAX_PATTERN_LEN;

  nmpm_ram #(.WIDTH(PAT_W), .DEPTH(NUM_SLOTS)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (waddr),
    .wdata_i (pat_wdata),
    .raddr_i (raddr),
    .rdata_o (pat_rdata)
  );

  nmpm_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (waddr),
    .wdata_i (slot_wdata),
    .raddr_i (raddr),
    .rdata_o (slot_rdata)
  );

  // ---------------------------------------------------------------- scan datapath
  assign len        = slot_rdata[LW-1:0];
  assign mode       = slot_rdata[MODE_LO +: 2];
  assign first_byte = (npos_q == '0);
  assign alive_o    = first_byte ? 1'b1 : slot_rdata[ALIVE_B];
  assign win_o      = first_byte ? '0 : slot_rdata[WIN_LO +: MAX_PATTERN_LEN];
  assign found_o    = first_byte ? 1'b0 : slot_rdata[FOUND_B];
  assign ch         = fold_char(item_q.data_byte);

  always_comb begin
    for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
      eq[i] = (LW'(i) < len) && (fold_char(pat_rdata[i*8 +: 8]) == ch);
    end
  end

  assign kill    = (npos_q < PSW'(len)) && !eq[PW'(npos_q)];
  assign alive_n = alive_o && !kill;
  assign win_n   = {win_o[MAX_PATTERN_LEN-2:0], 1'b1} & eq;
  assign found_n = found_o || ((len != '0) && win_n[PW'(len - LW'(1))]);
  assign pos_n   = (npos_q < PSW'(MAX_PATTERN_LEN + 1)) ? npos_q + PSW'(1) : npos_q;

  always_comb begin
    case (mode)
      MODE_EXACT:    slot_hit = alive_n && (pos_n == PSW'(len));
      MODE_CONTAINS: slot_hit = found_n;
      default:       slot_hit = alive_n && (pos_n >= PSW'(len));
    endcase
    slot_hit = slot_hit && (len != '0);
  end

  assign slot_upd = {found_n, win_n, alive_n, mode, len};

  // load path: insert a byte into the row, or replace length and mode
  assign len_sat = ({1'b0, item_q.pattern_len_in} > 7'(MAX_PATTERN_LEN))
                   ? LW'(MAX_PATTERN_LEN) : LW'(item_q.pattern_len_in);

  always_comb begin
    pat_wdata = pat_rdata;
    for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
      if (PW'(item_q.position) == PW'(i)) begin
        pat_wdata[i*8 +: 8] = item_q.data_byte;
      end
    end
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == CW'(NUM_SLOTS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.command)
            CMD_PAT_BYTE: begin
              if (int'(in_data_i.slot) < NUM_SLOTS &&
                  int'(in_data_i.position) < MAX_PATTERN_LEN) state_d = ST_LOAD_RD;
            end
            CMD_SLOT_CFG: begin
              if (int'(in_data_i.slot) < NUM_SLOTS) state_d = ST_LOAD_RD;
            end
            CMD_NAME_BYTE: state_d = ST_SCAN;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD_RD: state_d = ST_LOAD_WR;
      ST_LOAD_WR: state_d = ST_IDLE;
      ST_SCAN: begin
        if (cnt_q == CW'(NUM_SLOTS)) state_d = item_q.last ? ST_RESULT : ST_IDLE;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_ready_o  = 1'b0;
    raddr       = SW'(item_q.slot);
    waddr       = SW'(item_q.slot);
    pat_we      = 1'b0;
    slot_we     = 1'b0;
    slot_wdata  = slot_rdata;
    scan_wr     = 1'b0;
    out_load    = 1'b0;
    cnt_d       = cnt_q;
    npos_d      = npos_q;
    best_hit_d  = best_hit_q;
    best_slot_d = best_slot_q;
    unique case (state_q)
      ST_CLEAR: begin
        waddr      = cnt_q[SW-1:0];
        slot_we    = 1'b1;
        slot_wdata = '0;
        cnt_d      = cnt_q + CW'(1);
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        best_hit_d = 1'b0;
      end
      ST_LOAD_RD: begin
      end
      ST_LOAD_WR: begin
        if (item_q.command == CMD_PAT_BYTE) begin
          pat_we = slot_ok && pos_ok;
        end else begin
          slot_we    = slot_ok;
          slot_wdata = {slot_rdata[SLOT_W-1:LW+2], item_q.match_mode, len_sat};
        end
      end
      ST_SCAN: begin
        raddr   = cnt_q[SW-1:0];
        waddr   = ridx_q;
        scan_wr = (cnt_q != '0);
        slot_we = scan_wr;
        slot_wdata = slot_upd;
        cnt_d   = cnt_q + CW'(1);
        if (scan_wr && slot_hit && !best_hit_q) begin
          best_hit_d  = 1'b1;
          best_slot_d = ridx_q;
        end
        if (cnt_q == CW'(NUM_SLOTS)) begin
          npos_d = pos_n;
          cnt_d  = cnt_q;
        end
      end
      ST_RESULT: begin
        out_load = !out_valid_q || out_ready_i;
        if (out_load) npos_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (out_load)    out_valid_d = 1'b1;
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      npos_q      <= '0;
      best_hit_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      npos_q      <= npos_d;
      best_hit_q  <= best_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q      <= raddr;
    best_slot_q <= best_slot_d;
    if (accept) item_q <= in_data_i;
    if (out_load) begin
      out_data_q.matched    <= best_hit_q;
      out_data_q.match_slot <= best_hit_q ? 7'(best_slot_q) : 7'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------- assertions
  `NMPM_ASSERT_IMP(a_result_on_last_byte, clk_i, rst_ni, out_load, item_q.last && (item_q.command == CMD_NAME_BYTE), "result loaded without a last name byte")
  `NMPM_ASSERT_NXT(a_name_pos_cleared, clk_i, rst_ni, out_load, npos_q == '0, "name position not cleared after result")
  `NMPM_ASSERT_IMP(a_nomatch_slot_zero, clk_i, rst_ni, out_valid_o && !out_data_o.matched, out_data_o.match_slot == 7'd0, "slot index set without a match")

endmodule

`default_nettype wire

// File: verif/nocase_multi_pattern_name_match_tb.sv
// Self-checking testbench for the case-insensitive multi-pattern name matcher.
`timescale 1ns / 1ps

module nocase_multi_pattern_name_match_tb;
  import nmpm_pkg::*;

  localparam int NUM_SLOTS    = NUM_SLOTS_DEF;
  localparam int MAX_LEN      = MAX_PATTERN_LEN_DEF;
  localparam int RANDOM_WORDS = 1300;
  localparam int PRESS_CYCLES = 4000;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [1:0] MODE_PREFIX_ALT = 2'd3;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_word_t out_data_o;

  // shadow of the slot table and per-name match state
  logic [7:0]  pat_mem     [NUM_SLOTS][MAX_LEN];
  bit          pat_written [NUM_SLOTS][MAX_LEN];
  logic [5:0]  slot_len    [NUM_SLOTS];
  logic [1:0]  slot_md     [NUM_SLOTS];
  bit          prefix_ok   [NUM_SLOTS];
  logic [31:0] shift_win   [NUM_SLOTS];
  bit          seen_in_name[NUM_SLOTS];
  int unsigned name_pos;

  out_word_t pending_results[$];
  dir_row_t  directed_rows[$];
  int        words_sent   = 0;
  int        results_seen = 0;
  int        faults       = 0;
  bit        in_calm      = 1'b0;

  nocase_multi_pattern_name_match u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(20_000_000);
    $display("%0t: run timed out", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] to_lower(logic [7:0] b);
    return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? (b | 8'h20) : b;
  endfunction

  function automatic bit slot_hits(int s);
    if (slot_len[s] == 0) return 1'b0;
    case (slot_md[s])
      MODE_EXACT:    return prefix_ok[s] && name_pos == slot_len[s];
      MODE_CONTAINS: return seen_in_name[s];
      default:       return prefix_ok[s] && name_pos >= slot_len[s];
    endcase
  endfunction

  function automatic void clear_name();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      prefix_ok[s]    = 1'b1;
      shift_win[s]    = '0;
      seen_in_name[s] = 1'b0;
    end
    name_pos = 0;
  endfunction

  // Applies one accepted word to the shadow state; returns 1 when a result is due
  function automatic bit step_matcher(in_word_t w, output out_word_t res);
    logic [7:0]  c;
    logic [31:0] eq;
    bit          hit;
    res = '0;
    hit = 1'b0;
    case (w.command)
      CMD_PAT_BYTE: begin
        pat_mem[w.slot][w.position]     = w.data_byte;
        pat_written[w.slot][w.position] = 1'b1;
      end
      CMD_SLOT_CFG: begin
        slot_len[w.slot] = (w.pattern_len_in > MAX_LEN) ? 6'(MAX_LEN) : w.pattern_len_in;
        slot_md[w.slot]  = w.match_mode;
      end
      CMD_NAME_BYTE: begin
        c = to_lower(w.data_byte);
        for (int s = 0; s < NUM_SLOTS; s++) begin
          eq = '0;
          for (int i = 0; i < slot_len[s]; i++)
            if (to_lower(pat_mem[s][i]) == c) eq[i] = 1'b1;
          if (name_pos < slot_len[s] && to_lower(pat_mem[s][name_pos]) != c)
            prefix_ok[s] = 1'b0;
          shift_win[s] = ((shift_win[s] << 1) | 32'd1) & eq;
          if (slot_len[s] != 0 && shift_win[s][slot_len[s] - 1]) seen_in_name[s] = 1'b1;
        end
        if (name_pos < MAX_LEN + 1) name_pos++;
        if (w.last) begin
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!hit && slot_hits(s)) begin
              hit            = 1'b1;
              res.matched    = 1'b1;
              res.match_slot = 7'(s);
            end
          end
          clear_name();
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic in_word_t rand_fields();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(in_word_t)-1:0];
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] b);
    logic [7:0] up;
    up = b & 8'hdf;
    if (up >= CH_UPPER_A && up <= CH_UPPER_Z && $urandom_range(0, 1) == 1) return b ^ 8'h20;
    return b;
  endfunction

  // mostly a few letters so that names hit patterns; now and then case edges and raw bytes
  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return flip_case(8'h61 + 8'($urandom_range(0, 3)));
    if (r < 8) return flip_case(8'h61 + 8'($urandom_range(0, 25)));
    if (r == 8) begin
      case ($urandom_range(0, 5))
        0:       return 8'h40;
        1:       return 8'h5b;
        2:       return 8'h60;
        3:       return 8'h7b;
        4:       return 8'h00;
        default: return 8'hff;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_gap();
    int r;
    if (in_calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function automatic dir_row_t row(logic [1:0] cmd, int s, int p, logic [7:0] b, int len,
                                   logic [1:0] m, bit lst, bit typed = 1'b0, bit hit = 1'b0,
                                   int ms = 0);
    dir_row_t r;
    r.w                = '0;
    r.w.command        = cmd;
    r.w.slot           = 7'(s);
    r.w.position       = 5'(p);
    r.w.data_byte      = b;
    r.w.pattern_len_in = 6'(len);
    r.w.match_mode     = m;
    r.w.last           = lst;
    r.typed            = typed;
    r.want.matched     = hit;
    r.want.match_slot  = 7'(ms);
    return r;
  endfunction

  task automatic offer_word(input in_word_t w, input bit fixed_exp = 1'b0,
                            input out_word_t fixed = '0);
    int        gap;
    out_word_t res;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    if (step_matcher(w, res)) pending_results.push_back(fixed_exp ? fixed : res);
    if (w.command != CMD_UNUSED) words_sent++;
  endtask

  // Rewrites one slot; every byte below the new length that was never written is written first
  task automatic load_slot();
    int       s, len, lsel, eff;
    in_word_t w;
    s    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_SLOTS - 1) : $urandom_range(0, 11);
    lsel = $urandom_range(0, 19);
    if (lsel < 2) len = 0;
    else if (lsel == 2) len = $urandom_range(MAX_LEN, 63);
    else if (lsel == 3) len = $urandom_range(7, MAX_LEN - 1);
    else len = $urandom_range(1, 6);
    eff = (len > MAX_LEN) ? MAX_LEN : len;
    for (int p = 0; p < eff; p++) begin
      if (!pat_written[s][p] || $urandom_range(0, 4) == 0) begin
        w           = rand_fields();
        w.command   = CMD_PAT_BYTE;
        w.slot      = 7'(s);
        w.position  = 5'(p);
        w.data_byte = rand_char();
        offer_word(w);
      end
    end
    w                = rand_fields();
    w.command        = CMD_SLOT_CFG;
    w.slot           = 7'(s);
    w.pattern_len_in = 6'(len);
    w.match_mode     = 2'($urandom_range(0, 3));
    offer_word(w);
  endtask

  // Builds a name around an enabled pattern (exact, extended, embedded or cut short) or of random bytes
  task automatic send_name();
    logic [7:0] txt[$];
    int         picks[$];
    int         tgt, len, shape, n;
    in_word_t   w;
    tgt = 0;
    len = 0;
    for (int s = 0; s < NUM_SLOTS; s++)
      if (slot_len[s] != 0) picks.push_back(s);
    shape = (picks.size() == 0) ? 4 : $urandom_range(0, 4);
    if (shape < 4) begin
      tgt = picks[$urandom_range(0, picks.size() - 1)];
      len = slot_len[tgt];
    end
    if (shape == 2) repeat ($urandom_range(1, 3)) txt.push_back(rand_char());
    if (shape < 4) begin
      n = (shape == 3) ? len - 1 : len;
      for (int i = 0; i < n; i++) txt.push_back(flip_case(pat_mem[tgt][i]));
    end
    if (shape == 1) repeat ($urandom_range(1, 4)) txt.push_back(rand_char());
    if (shape == 2 || shape == 3) repeat ($urandom_range(0, 3)) txt.push_back(rand_char());
    if (shape == 4) begin
      // long names run the position counter into saturation
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10);
      repeat (n) txt.push_back(rand_char());
    end
    if (txt.size() == 0) txt.push_back(rand_char());
    foreach (txt[i]) begin
      if ($urandom_range(0, 29) == 0) load_slot();
      w           = rand_fields();
      w.command   = CMD_NAME_BYTE;
      w.data_byte = txt[i];
      w.last      = (i == txt.size() - 1);
      offer_word(w);
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_n && out_valid_o && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got matched=%0b slot=%0d",
                 $time, out_data_o.matched, out_data_o.match_slot);
        faults++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.matched !== want.matched) begin
          $display("%0t: matched wrong: expected %0b, got %0b",
                   $time, want.matched, out_data_o.matched);
          faults++;
        end
        if (out_data_o.match_slot !== want.match_slot) begin
          $display("%0t: match_slot wrong: expected %0d, got %0d",
                   $time, want.match_slot, out_data_o.match_slot);
          faults++;
        end
      end
    end
  end

  // Result side: random stalls, calm stretches, and one long hold-off to back up the input
  initial begin
    int hold;
    bit calm;
    bit pressed;
    hold    = 0;
    calm    = 1'b0;
    pressed = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk_i);
      if (!pressed && results_seen >= 20) begin
        pressed = 1'b1;
        hold    = PRESS_CYCLES;
      end else if (hold == 0 && $urandom_range(0, 199) == 0) begin
        calm = !calm;
      end
      if (hold == 0 && !calm && $urandom_range(0, 49) == 0) hold = $urandom_range(20, 80);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    in_word_t w;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_len[s] = '0;
      slot_md[s]  = '0;
      for (int p = 0; p < MAX_LEN; p++) begin
        pat_mem[s][p]     = '0;
        pat_written[s][p] = 1'b0;
      end
    end
    clear_name();

    directed_rows = '{
      row(CMD_NAME_BYTE, 0,   0,  8'h78, 0, MODE_PREFIX,     1, 1, 0, 0),   // nothing enabled
      row(CMD_PAT_BYTE,  5,   0,  8'h41, 0, MODE_PREFIX,     0),
      row(CMD_PAT_BYTE,  5,   1,  8'h62, 0, MODE_PREFIX,     0),
      row(CMD_SLOT_CFG,  5,   0,  8'h00, 2, MODE_PREFIX,     0),
      row(CMD_NAME_BYTE, 0,   0,  8'h61, 0, MODE_PREFIX,     0),
      row(CMD_NAME_BYTE, 0,   0,  8'h42, 0, MODE_PREFIX,     1, 1, 1, 5),   // folded prefix
      row(CMD_PAT_BYTE,  127, 0,  8'hff, 0, MODE_PREFIX,     0),
      row(CMD_SLOT_CFG,  127, 0,  8'h00, 1, MODE_CONTAINS,   0),
      row(CMD_NAME_BYTE, 0,   0,  8'h00, 0, MODE_PREFIX,     0),            // zero byte mid-name
      row(CMD_NAME_BYTE, 0,   0,  8'hff, 0, MODE_PREFIX,     1, 1, 1, 127), // top slot contains
      row(CMD_PAT_BYTE,  0,   0,  8'h5a, 0, MODE_PREFIX,     0),
      row(CMD_SLOT_CFG,  0,   0,  8'h00, 1, MODE_PREFIX_ALT, 0),
      row(CMD_NAME_BYTE, 0,   0,  8'h7a, 0, MODE_PREFIX,     1, 1, 1, 0),   // mode 3 as prefix
      row(CMD_SLOT_CFG,  0,   0,  8'h00, 0, MODE_PREFIX,     0),            // disable slot 0
      row(CMD_SLOT_CFG,  5,   0,  8'h00, 2, MODE_EXACT,      0),
      row(CMD_NAME_BYTE, 0,   0,  8'h61, 0, MODE_PREFIX,     0),
      row(CMD_NAME_BYTE, 0,   0,  8'h62, 0, MODE_PREFIX,     0),
      row(CMD_NAME_BYTE, 0,   0,  8'h63, 0, MODE_PREFIX,     1),            // exact too long
      row(CMD_UNUSED,    9,   31, 8'h55, 7, MODE_CONTAINS,   1),            // ignored command
      row(CMD_NAME_BYTE, 0,   0,  8'h41, 0, MODE_PREFIX,     0),
      row(CMD_NAME_BYTE, 0,   0,  8'h42, 0, MODE_PREFIX,     1, 1, 1, 5),   // exact, upper case
      row(CMD_PAT_BYTE,  1,   0,  8'h40, 0, MODE_PREFIX,     0),
      row(CMD_SLOT_CFG,  1,   0,  8'h00, 1, MODE_CONTAINS,   0),
      row(CMD_NAME_BYTE, 0,   0,  8'h60, 0, MODE_PREFIX,     1)             // no fold outside A-Z
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);

    while (words_sent < directed_rows.size() + RANDOM_WORDS) begin
      in_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) load_slot();
      if ($urandom_range(0, 9) == 0) begin
        // stray word: unused command or a pattern write that enables nothing
        w         = rand_fields();
        w.command = ($urandom_range(0, 1) == 0) ? CMD_UNUSED : CMD_PAT_BYTE;
        offer_word(w);
      end
      send_name();
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4 * NUM_SLOTS) @(posedge clk_i);
    if (faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/nmpm_pkg.sv
hw/rtl/nmpm_ram.sv
hw/rtl/nocase_multi_pattern_name_match.sv
verif/nocase_multi_pattern_name_match_tb.sv
